@@ rtl/core/jbs_pkg.sv @@
// Shared types and constants for the jittered backoff send scheduler.
// No dependencies; imported by every module under rtl/core.
package jbs_pkg;

  // Request kinds carried in tuser
  localparam logic [2:0] REQ_QUERY   = 3'd0;
  localparam logic [2:0] REQ_PAYLOAD = 3'd1;
  localparam logic [2:0] REQ_BUSY    = 3'd2;
  localparam logic [2:0] REQ_SEND    = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_RNG_SEED     = 3'd0;
  localparam logic [2:0] CFG_MAX_JITTER   = 3'd1;
  localparam logic [2:0] CFG_BASE_BACKOFF = 3'd2;
  localparam logic [2:0] CFG_MAX_BACKOFF  = 3'd3;
  localparam logic [2:0] CFG_SENSE_ENABLE = 3'd4;

  // Generator constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // Remainder unit: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LCG,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic exec;      // apply a request that needs no jitter
    logic lcg;       // advance generator, start remainder
    logic div_step;  // one remainder step
    logic jit_apply; // schedule now plus jitter
    logic load_out;  // fill the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_jitter;
    logic div_last;
  } dp_stat_t;

endpackage

@@ rtl/core/jbs_ctrl.sv @@
// Sequencer for the scheduler: walks each request through its steps.
// Depends on jbs_pkg; drives jbs_dp through ctrl_cmd_t.
module jbs_ctrl
  import jbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = stat_i.need_jitter ? ST_LCG : ST_DONE;
      ST_LCG:  state_d = ST_DIV;
      ST_DIV:  if (stat_i.div_last) state_d = ST_FIN;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: cmd_o.exec      = !stat_i.need_jitter;
      ST_LCG:  cmd_o.lcg       = 1'b1;
      ST_DIV:  cmd_o.div_step  = 1'b1;
      ST_FIN:  cmd_o.jit_apply = 1'b1;
      ST_DONE: cmd_o.load_out  = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/jbs_dp.sv @@
// Datapath: configuration registers, scheduler state, generator,
// bit-serial remainder and the result register. Depends on jbs_pkg.
module jbs_dp
  import jbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [IN_USER_W-1:0]  in_user_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  // Configuration
  logic [31:0] rng_seed_q;
  logic [15:0] max_jitter_q;
  logic [30:0] base_backoff_q;
  logic [30:0] max_backoff_q;
  logic        sense_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_seed_q     <= 32'd1;
      max_jitter_q   <= '0;
      base_backoff_q <= '0;
      max_backoff_q  <= '0;
      sense_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RNG_SEED:     rng_seed_q     <= cfg_data_i;
        CFG_MAX_JITTER:   max_jitter_q   <= cfg_data_i[15:0];
        CFG_BASE_BACKOFF: base_backoff_q <= cfg_data_i[30:0];
        CFG_MAX_BACKOFF:  max_backoff_q  <= cfg_data_i[30:0];
        CFG_SENSE_ENABLE: sense_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Latched request
  logic [2:0]  req_q;
  logic [31:0] now_q;
  logic        ok_q;
  logic        avail_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= in_user_i;
      now_q   <= in_data_i[31:0];
      ok_q    <= in_data_i[32];
      avail_q <= in_data_i[33];
    end
  end

  // Scheduler state
  logic [31:0] rand_q, rand_d;
  logic [30:0] backoff_q, backoff_d;
  logic        pending_q, pending_d;
  logic [31:0] attempt_q, attempt_d;

  // Remainder unit
  logic [31:0]      dvd_q, dvd_d;
  logic [15:0]      rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [31:0] rand_next;
  logic [31:0] twice;
  logic [30:0] grown;
  logic [16:0] divisor;
  logic [16:0] trial;

  // Generator step, truncated to 32 bits
  assign rand_next = 32'(rand_q * LCG_MUL) + LCG_ADD;

  // Backoff growth: base first, then doubled with cap
  assign twice = {backoff_q, 1'b0};
  always_comb begin
    if (backoff_q == '0) begin
      grown = base_backoff_q;
    end else if (twice > {1'b0, max_backoff_q}) begin
      grown = max_backoff_q;
    end else begin
      grown = twice[30:0];
    end
  end

  // Restoring remainder step; partial remainder stays below the divisor
  assign divisor = {1'b0, max_jitter_q} + 17'd1;
  assign trial   = {rem_q, dvd_q[31]};

  always_comb begin
    rand_d    = rand_q;
    backoff_d = backoff_q;
    pending_d = pending_q;
    attempt_d = attempt_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    if (cmd_i.exec) begin
      case (req_q)
        REQ_PAYLOAD: begin
          pending_d = 1'b1;
          attempt_d = now_q;
        end
        REQ_BUSY: begin
          backoff_d = grown;
          attempt_d = now_q + {1'b0, grown};
        end
        REQ_SEND: begin
          if (ok_q) begin
            pending_d = 1'b0;
            backoff_d = '0;
          end else begin
            backoff_d = grown;
            attempt_d = now_q + {1'b0, grown};
          end
        end
        REQ_RESTART: begin
          rand_d    = (rng_seed_q == '0) ? 32'd1 : rng_seed_q;
          backoff_d = '0;
          pending_d = 1'b0;
          attempt_d = '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.lcg) begin
      rand_d = rand_next;
      dvd_d  = rand_next;
      rem_d  = '0;
      cnt_d  = '0;
    end
    if (cmd_i.div_step) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (trial >= divisor) begin
        rem_d = 16'(trial - divisor);
      end else begin
        rem_d = trial[15:0];
      end
    end
    if (cmd_i.jit_apply) begin
      pending_d = 1'b1;
      attempt_d = now_q + {16'd0, rem_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rand_q    <= 32'd1;
      backoff_q <= '0;
      pending_q <= 1'b0;
      attempt_q <= '0;
    end else begin
      rand_q    <= rand_d;
      backoff_q <= backoff_d;
      pending_q <= pending_d;
      attempt_q <= attempt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign stat_o.need_jitter = (req_q == REQ_PAYLOAD) && (max_jitter_q != '0);
  assign stat_o.div_last    = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Result register
  logic [OUT_DATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {6'd0, backoff_q, attempt_q, sense_enable_q & avail_q, pending_q,
                pending_q && (now_q >= attempt_q)};
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/core/jittered_backoff_send_scheduler_unit.sv @@
// Top level of the jittered backoff send scheduler.
// Depends on jbs_pkg, jbs_ctrl and jbs_dp.
//
//  channel  direction  payload (low bit first)
//  s_axis   in         tdata: now_time, send_ok, sense_available; tuser: req_type
//  m_axis   out        tdata: ready_to_send, payload_waiting, sense_first,
//                             next_attempt_time, backoff_delay
//  cfg      in         write enable, register index, 32-bit data
//
// A payload-built request with nonzero max_jitter steps through capture, the execute
// step, one generator step, 32 remainder steps, the jitter add and the result load.
// Every other request steps through capture, the execute step and the result load.
// One request is in flight at a time; the next is accepted while the previous result
// waits in the output register, and an untaken result holds the following one in its
// load step.
// Reset is asynchronous and active low; no clearing pass is needed.
module jittered_backoff_send_scheduler_unit
  import jbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [31:0] now_time, [32] send_ok, [33] sense_available, [39:34] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] req_type
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] ready_to_send, [1] payload_waiting, [2] sense_first,
  // [34:3] next_attempt_time, [65:35] backoff_delay, [71:66] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  jbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  jbs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted request blocks the input until it has been worked through
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // Ready to send implies a pending payload
  a_ready_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && !m_axis_tdata_o[1]))
    else $error("ready_to_send without pending payload");

  // Only one command is issued to the datapath per cycle
  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("overlapping datapath commands");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for jittered_backoff_send_scheduler_unit.
// Depends on jbs_pkg and the scheduler RTL. It runs a directed table, then random
// request traffic, and checks each status against its typed row or a built-in model.
module tb_top;
  import jbs_pkg::*;

  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned QUIET_LIMIT      = 4000;
  localparam int unsigned BLOCK_ITEMS      = 70;
  localparam int unsigned BLOCKS_PER_PHASE = 5;
  localparam int unsigned REPORT_LIMIT     = 10;

  // Generator constants, kept apart from the RTL's copy
  localparam logic [31:0] GEN_MUL = 32'd1664525;
  localparam logic [31:0] GEN_INC = 32'd1013904223;

  // Undefined request kinds, treated as a query
  localparam logic [2:0] REQ_SPARE_5 = 3'd5;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // Same bit order as m_axis_tdata: ready lowest, backoff highest
  typedef struct packed {
    logic [30:0] backoff;
    logic [31:0] next;
    logic        sense;
    logic        pending;
    logic        ready;
  } status_t;

  typedef struct {
    logic        is_write; // register write rather than a request
    logic [2:0]  code;     // request kind, or register index
    logic [31:0] value;    // now_time, or register data
    logic        ok;
    logic        avail;
    logic        typed;    // use the hand-written status below
    status_t     want;
  } plan_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Model copy of the registers
  logic [31:0] seed_r       = 32'd1;
  logic [15:0] jitter_max_r = '0;
  logic [30:0] base_r       = '0;
  logic [30:0] cap_r        = '0;
  logic        sense_en_r   = 1'b0;

  // Model copy of the scheduler state
  logic [31:0] lcg_s     = 32'd1;
  logic [30:0] backoff_s = '0;
  logic        pending_s = 1'b0;
  logic [31:0] attempt_s = '0;

  status_t     awaited_q[$];
  plan_row_t   plan_q[$];
  int unsigned bad_results  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  logic [31:0] wall_ms      = '0;

  jittered_backoff_send_scheduler_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Backoff growth: base first, then doubling up to the cap
  function automatic void widen_backoff();
    logic [31:0] doubled;
    if (backoff_s == '0) begin
      backoff_s = base_r;
    end else begin
      doubled   = {backoff_s, 1'b0};
      backoff_s = (doubled > {1'b0, cap_r}) ? cap_r : doubled[30:0];
    end
  endfunction

  // Apply one request to the model and return the status it reports
  function automatic status_t advance_scheduler(logic [2:0] req, logic [31:0] now,
                                                logic ok, logic avail);
    status_t     st;
    logic [31:0] jitter;
    case (req)
      REQ_PAYLOAD: begin
        jitter = '0;
        if (jitter_max_r != '0) begin
          lcg_s  = lcg_s * GEN_MUL + GEN_INC;
          jitter = lcg_s % ({16'd0, jitter_max_r} + 32'd1);
        end
        pending_s = 1'b1;
        attempt_s = now + jitter;
      end
      REQ_BUSY: begin
        widen_backoff();
        attempt_s = now + {1'b0, backoff_s};
      end
      REQ_SEND: begin
        if (ok) begin
          pending_s = 1'b0;
          backoff_s = '0;
        end else begin
          widen_backoff();
          attempt_s = now + {1'b0, backoff_s};
        end
      end
      REQ_RESTART: begin
        lcg_s     = (seed_r == '0) ? 32'd1 : seed_r;
        backoff_s = '0;
        pending_s = 1'b0;
        attempt_s = '0;
      end
      default: ;
    endcase
    st.ready   = pending_s && (now >= attempt_s);
    st.pending = pending_s;
    st.sense   = sense_en_r & avail;
    st.next    = attempt_s;
    st.backoff = backoff_s;
    return st;
  endfunction

  // Directed table entries
  function automatic void plan_req(logic [2:0] code, logic [31:0] now, logic ok, logic avail);
    plan_row_t row;
    row = '{1'b0, code, now, ok, avail, 1'b0, '0};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_req_known(logic [2:0] code, logic [31:0] now, logic ok,
                                         logic avail, logic rdy, logic pend, logic sns,
                                         logic [31:0] nxt, logic [30:0] boff);
    plan_row_t row;
    row = '{1'b0, code, now, ok, avail, 1'b1, '0};
    row.want.ready   = rdy;
    row.want.pending = pend;
    row.want.sense   = sns;
    row.want.next    = nxt;
    row.want.backoff = boff;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_reg(logic [2:0] idx, logic [31:0] val);
    plan_row_t row;
    row = '{1'b1, idx, val, 1'b0, 1'b0, 1'b0, '0};
    plan_q.push_back(row);
  endfunction

  // Offer one request, wait for it to be taken, record the status it should give
  task automatic push_request(input logic [2:0] req, input logic [31:0] now, input logic ok,
                              input logic avail, input logic typed, input status_t want);
    status_t model;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W-34){1'b0}}, avail, ok, now};
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model = advance_scheduler(req, now, ok, avail);
    awaited_q.push_back(typed ? want : model);
  endtask

  // Random sender gap after a request
  task automatic sender_pause();
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Register write once the block has gone quiet
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    s_axis_tvalid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_RNG_SEED:     seed_r       = val;
      CFG_MAX_JITTER:   jitter_max_r = val[15:0];
      CFG_BASE_BACKOFF: base_r       = val[30:0];
      CFG_MAX_BACKOFF:  cap_r        = val[30:0];
      CFG_SENSE_ENABLE: sense_en_r   = val[0];
      default: ;
    endcase
  endtask

  // New register set, extremes favoured
  task automatic random_settings();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    write_reg(CFG_RNG_SEED, v);
    case ($urandom_range(4))
      0: v = '0;
      1: v = 32'd1;
      2: v = 32'h0000_FFFF;
      default: v = $urandom_range(300, 1);
    endcase
    write_reg(CFG_MAX_JITTER, v);
    case ($urandom_range(4))
      0: v = '0;
      1: v = 32'd1;
      2: v = 32'h7FFF_FFFF;
      default: v = $urandom_range(500, 1);
    endcase
    write_reg(CFG_BASE_BACKOFF, v);
    case ($urandom_range(3))
      0: v = '0;
      1: v = 32'h7FFF_FFFF;
      default: v = $urandom_range(5000, 1);
    endcase
    write_reg(CFG_MAX_BACKOFF, v);
    write_reg(CFG_SENSE_ENABLE, $urandom_range(1));
  endtask

  // One random request; times mostly creep forward or sit near the attempt time
  task automatic random_request();
    logic [2:0]  req;
    logic [31:0] now;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) begin
      req = REQ_PAYLOAD;
    end else if (roll < 35) begin
      req = REQ_BUSY;
    end else if (roll < 60) begin
      req = REQ_SEND;
    end else if (roll < 85) begin
      req = REQ_QUERY;
    end else if (roll < 90) begin
      req = REQ_RESTART;
    end else begin
      case ($urandom_range(2))
        0: req = REQ_SPARE_5;
        1: req = REQ_SPARE_6;
        default: req = REQ_SPARE_7;
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 10) begin
      now = $urandom;
    end else if (roll < 40) begin
      now = attempt_s + $urandom_range(2) - 32'd1;
    end else begin
      now = wall_ms + $urandom_range(40);
    end
    wall_ms = now;
    push_request(req, now, $urandom_range(1), $urandom_range(1), 1'b0, '0);
  endtask

  // Result side: check each status taken, then pick the next ready
  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[$bits(status_t)-1:0];
      if (awaited_q.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_LIMIT)
          $display("stray status %h with nothing outstanding", got);
      end else begin
        want = awaited_q.pop_front();
        if (got.ready !== want.ready || got.pending !== want.pending ||
            got.sense !== want.sense || got.next !== want.next ||
            got.backoff !== want.backoff) begin
          bad_results++;
          if (bad_results <= REPORT_LIMIT)
            $display("status: expected rdy=%b pend=%b sense=%b next=%h boff=%h, got rdy=%b pend=%b sense=%b next=%h boff=%h",
                     want.ready, want.pending, want.sense, want.next, want.backoff,
                     got.ready, got.pending, got.sense, got.next, got.backoff);
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    plan_row_t row;

    // After reset: nothing pending, everything zero
    plan_req_known(REQ_QUERY, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 31'd0);
    plan_req_known(REQ_QUERY, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 31'd0);
    // Zero jitter: attempt at now, ready at once
    plan_req_known(REQ_PAYLOAD, 32'd100, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'd100, 31'd0);
    plan_req_known(REQ_QUERY, 32'd99, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd100, 31'd0);
    // Backoff: base, doubled, then capped
    plan_reg(CFG_BASE_BACKOFF, 32'd10);
    plan_reg(CFG_MAX_BACKOFF, 32'd25);
    plan_req_known(REQ_BUSY, 32'd200, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd210, 31'd10);
    plan_req_known(REQ_SEND, 32'd230, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd250, 31'd20);
    plan_req_known(REQ_BUSY, 32'd300, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd325, 31'd25);
    // Success keeps the attempt time
    plan_req_known(REQ_SEND, 32'd400, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd325, 31'd0);
    // Busy with nothing pending still acts
    plan_req_known(REQ_BUSY, 32'd500, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd510, 31'd10);
    plan_reg(CFG_SENSE_ENABLE, 32'd1);
    plan_req_known(REQ_QUERY, 32'd510, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'd510, 31'd10);
    // Restart with a zero seed, then widest jitter across the wrap
    plan_reg(CFG_RNG_SEED, 32'd0);
    plan_reg(CFG_MAX_JITTER, 32'h0000_FFFF);
    plan_req_known(REQ_RESTART, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 31'd0);
    plan_req(REQ_PAYLOAD, 32'hFFFF_FFF0, 1'b0, 1'b1);
    plan_req(REQ_SPARE_5, 32'h8000_0000, 1'b1, 1'b1);
    plan_req(REQ_SPARE_6, 32'hFFFF_FFFF, 1'b0, 1'b0);
    plan_req(REQ_SPARE_7, 32'h0000_0000, 1'b1, 1'b1);
    // Base above the cap, then a zero cap drops it
    plan_reg(CFG_BASE_BACKOFF, 32'h7FFF_FFFF);
    plan_reg(CFG_MAX_BACKOFF, 32'd0);
    plan_req(REQ_SEND, 32'd0, 1'b0, 1'b1);
    plan_req(REQ_BUSY, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // All-ones seed, smallest nonzero jitter
    plan_reg(CFG_RNG_SEED, 32'hFFFF_FFFF);
    plan_req(REQ_RESTART, 32'd1000, 1'b0, 1'b1);
    plan_reg(CFG_MAX_JITTER, 32'd1);
    plan_req(REQ_PAYLOAD, 32'd1000, 1'b0, 1'b1);
    plan_req(REQ_PAYLOAD, 32'd1001, 1'b1, 1'b0);
    plan_req(REQ_QUERY, 32'd1002, 1'b0, 1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 15;
    rx_idle_pct = 80;
    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.is_write) begin
        write_reg(row.code, row.value);
      end else begin
        push_request(row.code, row.value, row.ok, row.avail, row.typed, row.want);
        sender_pause();
      end
    end

    // Random traffic in three idling phases, fresh registers per block
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 80;
        end
        1: begin
          tx_idle_pct = 80;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        random_settings();
        push_request(REQ_RESTART, wall_ms, 1'b0, $urandom_range(1), 1'b0, '0);
        sender_pause();
        repeat (BLOCK_ITEMS) begin
          random_request();
          sender_pause();
        end
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bad_results == 0 && awaited_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
